// File: rtl/core/jets_pkg.sv
// ----------------------------------------------------------------------------
// jets_pkg
// Shared types, constants and helpers for the julia escape-time block.
// ----------------------------------------------------------------------------
package jets_pkg;

  localparam int DEF_IMAGE_WIDTH  = 1024;
  localparam int DEF_IMAGE_HEIGHT = 1024;
  localparam int FRAC_BITS        = 28;
  localparam int NUM_CELLS        = 4;
  localparam int MAG_W            = 43;
  localparam int LOG_W            = 23;
  localparam int SUM_W            = 36;
  localparam int NEG_LOG2_LN2_Q16 = 34653;

  localparam logic [SUM_W-1:0] ESCAPE_BOUND = SUM_W'(64'd4 << FRAC_BITS);

  localparam logic [2:0] REG_CONST_REAL    = 3'd0;
  localparam logic [2:0] REG_CONST_IMAG    = 3'd1;
  localparam logic [2:0] REG_VIEW_MIN_REAL = 3'd2;
  localparam logic [2:0] REG_VIEW_MAX_REAL = 3'd3;
  localparam logic [2:0] REG_VIEW_MIN_IMAG = 3'd4;
  localparam logic [2:0] REG_VIEW_MAX_IMAG = 3'd5;
  localparam logic [2:0] REG_ITER_LIMIT    = 3'd6;

  typedef struct packed {
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
  } in_t;

  typedef struct packed {
    logic [19:0] smooth_count;
    logic        inside_set;
  } out_t;

  typedef struct packed {
    logic signed [31:0] const_real;
    logic signed [31:0] const_imag;
    logic [11:0]        iteration_limit;
  } cell_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic [11:0]        iter;
    logic [SUM_W-1:0]   sum;
  } ring_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic [16:0] log_tab(input logic [4:0] idx);
    logic [16:0] t;
    case (idx)
      5'd0:    t = 17'd0;
      5'd1:    t = 17'd5732;
      5'd2:    t = 17'd11136;
      5'd3:    t = 17'd16248;
      5'd4:    t = 17'd21098;
      5'd5:    t = 17'd25711;
      5'd6:    t = 17'd30109;
      5'd7:    t = 17'd34312;
      5'd8:    t = 17'd38336;
      5'd9:    t = 17'd42196;
      5'd10:   t = 17'd45904;
      5'd11:   t = 17'd49472;
      5'd12:   t = 17'd52911;
      5'd13:   t = 17'd56229;
      5'd14:   t = 17'd59434;
      5'd15:   t = 17'd62534;
      5'd16:   t = 17'd65536;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/jets_div.sv
// ----------------------------------------------------------------------------
// jets_div
// Division by a fixed divisor through a reciprocal multiply, four partial
// products accumulated in turn.
// ----------------------------------------------------------------------------
module jets_div #(
  parameter int DIVISOR = jets_pkg::DEF_IMAGE_WIDTH,
  parameter int DW      = jets_pkg::MAG_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int SH = DW + $clog2(DIVISOR);
  localparam int HW = (DW + 2) / 2;
  localparam int AW = 4 * HW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [2*HW-1:0] RECIP_W = (2*HW)'(RECIP);
  localparam logic [HW-1:0] M_LO = RECIP_W[HW-1:0];
  localparam logic [HW-1:0] M_HI = RECIP_W[2*HW-1:HW];

  logic [2*HW-1:0] x;
  logic [AW-1:0]   acc;
  logic [1:0]      step;
  logic            busy;
  logic [HW-1:0]   op_a;
  logic [HW-1:0]   op_b;
  logic [2*HW-1:0] part;
  logic [AW-1:0]   term;

  assign op_a     = step[1] ? x[2*HW-1:HW] : x[HW-1:0];
  assign op_b     = step[0] ? M_HI : M_LO;
  assign part     = op_a * op_b;
  assign quotient = DW'(acc >> SH);

  always_comb begin
    case (step)
      2'd0:    term = AW'(part);
      2'd3:    term = {part, {(2*HW){1'b0}}};
      default: term = AW'({part, {HW{1'b0}}});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == 2'd3);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= (2*HW)'(dividend);
      acc <= '0;
    end else if (busy) begin
      acc <= acc + term;
    end
  end

endmodule

// File: rtl/core/jets_log.sv
// ----------------------------------------------------------------------------
// jets_log
// Table based log2 in Q16: serial leading-one search, then interpolation.
// ----------------------------------------------------------------------------
module jets_log (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [jets_pkg::SUM_W-1:0] arg,
  output logic                       done,
  output logic [jets_pkg::LOG_W-1:0] result
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_ADD  = 2'd3;

  logic [1:0]                       state;
  logic [jets_pkg::SUM_W-1:0]       w;
  logic [5:0]                       p;
  logic [jets_pkg::LOG_W-1:0]       base;
  logic [24:0]                      frac_prod;
  logic [4:0]                       idx;
  logic [11:0]                      rem;
  logic [16:0]                      t0;
  logic [16:0]                      t1;
  logic [16:0]                      tdiff;

  assign idx   = {1'b0, w[34:31]};
  assign rem   = w[30:19];
  assign t0    = jets_pkg::log_tab(idx);
  assign t1    = jets_pkg::log_tab(idx + 5'd1);
  assign tdiff = t1 - t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == L_ADD);
      unique case (state)
        L_IDLE: if (start) state <= L_NORM;
        L_NORM: if (w[jets_pkg::SUM_W-1] || p == 6'd0) state <= L_MUL;
        L_MUL:  state <= L_ADD;
        L_ADD:  state <= L_IDLE;
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == L_IDLE && start) begin
      w <= arg;
      p <= 6'(jets_pkg::SUM_W - 1);
    end else if (state == L_NORM && !w[jets_pkg::SUM_W-1] && p != 6'd0) begin
      w <= {w[jets_pkg::SUM_W-2:0], 1'b0};
      p <= p - 6'd1;
    end
    if (state == L_MUL) begin
      frac_prod <= tdiff[12:0] * rem;
      base      <= jets_pkg::LOG_W'({p, 16'd0}) + jets_pkg::LOG_W'(t0);
    end
    if (state == L_ADD) begin
      result <= base + jets_pkg::LOG_W'(frac_prod[24:12]);
    end
  end

endmodule

// File: rtl/core/jets_cell.sv
// ----------------------------------------------------------------------------
// jets_cell
// One ring cell: squares and cross product, then escape test and z update.
// ----------------------------------------------------------------------------
module jets_cell (
  input  logic                clk,
  input  logic                rst,
  input  jets_pkg::cell_cfg_t cfg,
  input  jets_pkg::ring_t     din,
  output jets_pkg::ring_t     dout
);

  logic signed [63:0]         prr;
  logic signed [63:0]         pii;
  logic signed [63:0]         pri;
  logic                       m_valid;
  logic                       m_done;
  logic signed [31:0]         m_zr;
  logic signed [31:0]         m_zi;
  logic [11:0]                m_iter;
  logic [jets_pkg::SUM_W-1:0] m_sum;
  logic [34:0]                m_sqr;
  logic [34:0]                m_sqi;
  logic signed [35:0]         m_xp;
  logic [jets_pkg::SUM_W-1:0] sum;
  logic                       stop;
  logic signed [36:0]         nr_w;
  logic signed [36:0]         ni_w;

  assign prr = din.zr * din.zr;
  assign pii = din.zi * din.zi;
  assign pri = din.zr * din.zi;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    m_done <= din.done;
    m_zr   <= din.zr;
    m_zi   <= din.zi;
    m_iter <= din.iter;
    m_sum  <= din.sum;
    m_sqr  <= prr[62:28];
    m_sqi  <= pii[62:28];
    m_xp   <= pri[62:27];
  end

  assign sum  = {1'b0, m_sqr} + {1'b0, m_sqi};
  assign stop = m_done || (sum > jets_pkg::ESCAPE_BOUND) || (m_iter >= cfg.iteration_limit);
  assign nr_w = $signed({2'b00, m_sqr}) - $signed({2'b00, m_sqi}) + 37'(cfg.const_real);
  assign ni_w = 37'(m_xp) + 37'(cfg.const_imag);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stop) begin
      dout.done <= 1'b1;
      dout.zr   <= m_zr;
      dout.zi   <= m_zi;
      dout.iter <= m_iter;
      dout.sum  <= m_done ? m_sum : sum;
    end else begin
      dout.done <= 1'b0;
      dout.zr   <= jets_pkg::sat32(48'(nr_w));
      dout.zi   <= jets_pkg::sat32(48'(ni_w));
      dout.iter <= m_iter + 12'd1;
      dout.sum  <= sum;
    end
  end

endmodule

// File: rtl/core/julia_escape_time_smooth.sv
// ----------------------------------------------------------------------------
// julia_escape_time_smooth
// Julia set escape time per pixel with smoothed fractional count.
// ----------------------------------------------------------------------------
// flow: coordinate mapping and reciprocal division, then the iterations in a ring
// of NUM_CELLS two-stage cells (rounded up to a full ring pass), then two serial
// log2 passes for escaped points
// throughput: one pixel at a time, set by the iteration count of the ring
// reset: synchronous, registers return to their reset values, pipeline empties
module julia_escape_time_smooth #(
  parameter int IMAGE_WIDTH  = jets_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = jets_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  jets_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output jets_pkg::out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RING = 3'd3;
  localparam logic [2:0] S_LOG1 = 3'd4;
  localparam logic [2:0] S_LOG2 = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam int MW = jets_pkg::MAG_W;
  localparam int NC = jets_pkg::NUM_CELLS;

  logic [2:0]          state;
  logic signed [31:0]  const_real;
  logic signed [31:0]  const_imag;
  logic signed [31:0]  view_min_real;
  logic signed [31:0]  view_max_real;
  logic signed [31:0]  view_min_imag;
  logic signed [31:0]  view_max_imag;
  logic [11:0]         iteration_limit;

  logic [9:0]          col;
  logic [9:0]          row;
  logic signed [32:0]  diff_re;
  logic signed [32:0]  diff_im;
  logic signed [43:0]  prod_re;
  logic signed [43:0]  prod_im;
  logic signed [43:0]  abs_re;
  logic signed [43:0]  abs_im;
  logic                neg_re;
  logic                neg_im;
  logic                div_start;
  logic [MW-1:0]       q_re;
  logic [MW-1:0]       q_im;
  logic                done_re;
  logic                done_im;
  logic                div_done;
  logic signed [43:0]  qs_re;
  logic signed [43:0]  qs_im;

  jets_pkg::cell_cfg_t cell_cfg;
  jets_pkg::ring_t     link [NC+1];
  jets_pkg::ring_t     seed;
  logic                inject;
  jets_pkg::ring_t     last;

  logic [11:0]                    fin_iter;
  logic                           log_start;
  logic [jets_pkg::SUM_W-1:0]     log_arg;
  logic                           log_done;
  logic [jets_pkg::LOG_W-1:0]     log_res;
  logic signed [23:0]             l1;
  logic signed [23:0]             l2;
  logic [12:0]                    iter_p2;
  logic signed [30:0]             r;
  logic signed [30:0]             rr;
  logic [19:0]                    limit_q8;
  logic [19:0]                    count;
  jets_pkg::out_t                 res;

  always_ff @(posedge clk) begin
    if (rst) begin
      const_real      <= '0;
      const_imag      <= '0;
      view_min_real   <= -32'sd536870912;
      view_max_real   <= 32'sd536870912;
      view_min_imag   <= -32'sd536870912;
      view_max_imag   <= 32'sd536870912;
      iteration_limit <= 12'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        jets_pkg::REG_CONST_REAL:    const_real      <= cfg_data;
        jets_pkg::REG_CONST_IMAG:    const_imag      <= cfg_data;
        jets_pkg::REG_VIEW_MIN_REAL: view_min_real   <= cfg_data;
        jets_pkg::REG_VIEW_MAX_REAL: view_max_real   <= cfg_data;
        jets_pkg::REG_VIEW_MIN_IMAG: view_min_imag   <= cfg_data;
        jets_pkg::REG_VIEW_MAX_IMAG: view_max_imag   <= cfg_data;
        jets_pkg::REG_ITER_LIMIT:    iteration_limit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // coordinate mapping
  assign diff_re   = 33'(view_max_real) - 33'(view_min_real);
  assign diff_im   = 33'(view_max_imag) - 33'(view_min_imag);
  assign prod_re   = $signed({34'd0, col}) * 44'(diff_re);
  assign prod_im   = $signed({34'd0, row}) * 44'(diff_im);
  assign abs_re    = prod_re[43] ? -prod_re : prod_re;
  assign abs_im    = prod_im[43] ? -prod_im : prod_im;
  assign div_start = (state == S_MAP);
  assign div_done  = done_re && done_im;

  jets_div #(.DIVISOR(IMAGE_WIDTH), .DW(MW)) u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abs_re[MW-1:0]),
    .quotient (q_re),
    .done     (done_re)
  );

  jets_div #(.DIVISOR(IMAGE_HEIGHT), .DW(MW)) u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abs_im[MW-1:0]),
    .quotient (q_im),
    .done     (done_im)
  );

  assign qs_re = neg_re ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
  assign qs_im = neg_im ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});

  always_comb begin
    seed       = '0;
    seed.valid = 1'b1;
    seed.zr    = jets_pkg::sat32(48'(view_min_real) + 48'(qs_re));
    seed.zi    = jets_pkg::sat32(48'(view_max_imag) - 48'(qs_im));
  end

  // iteration ring
  assign inject   = (state == S_DIV) && div_done;
  assign last     = link[NC];
  assign cell_cfg = '{const_real: const_real, const_imag: const_imag,
                      iteration_limit: iteration_limit};

  always_comb begin
    link[0]       = last;
    link[0].valid = last.valid && !last.done;
    if (inject) link[0] = seed;
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    jets_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cell_cfg),
      .din  (link[k]),
      .dout (link[k+1])
    );
  end

  jets_log u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .arg    (log_arg),
    .done   (log_done),
    .result (log_res)
  );

  // smoothing
  assign l1       = $signed({1'b0, log_res}) - 24'sd1835008;
  assign l2       = $signed({1'b0, log_res}) - 24'sd1048576;
  assign iter_p2  = 13'(fin_iter) + 13'd2;
  assign r        = $signed({2'b00, iter_p2, 16'd0}) + 31'(jets_pkg::NEG_LOG2_LN2_Q16)
                    - 31'(l2);
  assign rr       = r + 31'sd128;
  assign limit_q8 = {iteration_limit, 8'd0};

  always_comb begin
    if (r < 0) begin
      count = '0;
    end else if (rr[30:8] > 23'(limit_q8)) begin
      count = limit_q8;
    end else begin
      count = rr[27:8];
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      log_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      log_start <= (state == S_RING && last.valid && last.done &&
                    last.iter != iteration_limit) ||
                   (state == S_LOG1 && log_done);
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_MAP;
        S_MAP:  state <= S_DIV;
        S_DIV:  if (div_done) state <= S_RING;
        S_RING: begin
          if (last.valid && last.done) begin
            if (last.iter == iteration_limit) begin
              state <= S_DONE;
            end else begin
              state <= S_LOG1;
            end
          end
        end
        S_LOG1: if (log_done) state <= S_LOG2;
        S_LOG2: if (log_done) state <= S_DONE;
        S_DONE: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      col <= in_data.pixel_col;
      row <= in_data.pixel_row;
    end
    if (state == S_MAP) begin
      neg_re <= prod_re[43];
      neg_im <= prod_im[43];
    end
    if (state == S_RING && last.valid && last.done) begin
      fin_iter <= last.iter;
      log_arg  <= last.sum;
      res      <= '{smooth_count: limit_q8, inside_set: 1'b1};
    end
    if (state == S_LOG1 && log_done) begin
      log_arg <= (l1 < 24'sd1) ? jets_pkg::SUM_W'(1) : jets_pkg::SUM_W'(l1[22:0]);
    end
    if (state == S_LOG2 && log_done) begin
      res <= '{smooth_count: count, inside_set: 1'b0};
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/core/jets_checker.sv
// ----------------------------------------------------------------------------
// jets_checker
// Port level checks for the julia escape-time block.
// ----------------------------------------------------------------------------
module jets_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input jets_pkg::out_t out_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // one pixel at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // inside points carry a whole count
  a_inside_whole: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.inside_set) |-> (out_data.smooth_count[7:0] == 8'd0))
    else $error("inside result with fraction");

endmodule

bind julia_escape_time_smooth jets_checker u_jets_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/julia_escape_time_smooth_test.sv
// ----------------------------------------------------------------------------
// julia_escape_time_smooth_test
// Self-checking bench for the julia escape-time block. Pixels go in under
// random gaps and output back-pressure, through several constant, window and
// limit settings. Every result is compared with an independent prediction.
// ----------------------------------------------------------------------------
class escape_scoreboard;
  jets_pkg::out_t expected_counts[$];
  longint c_re, c_im, min_re, max_re, min_im, max_im;
  int unsigned limit;
  int errors, results, inside_hits, sat_hits;
  longint ltab[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                       42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

  function new();
    c_re = 0; c_im = 0;
    min_re = -536870912; max_re = 536870912;
    min_im = -536870912; max_im = 536870912;
    limit = 100;
  endfunction

  function void configure(logic [2:0] idx, logic [31:0] data);
    longint v;
    v = longint'($signed(data));
    case (idx)
      jets_pkg::REG_CONST_REAL:    c_re = v;
      jets_pkg::REG_CONST_IMAG:    c_im = v;
      jets_pkg::REG_VIEW_MIN_REAL: min_re = v;
      jets_pkg::REG_VIEW_MAX_REAL: max_re = v;
      jets_pkg::REG_VIEW_MIN_IMAG: min_im = v;
      jets_pkg::REG_VIEW_MAX_IMAG: max_im = v;
      jets_pkg::REG_ITER_LIMIT:    limit = 32'(data[11:0]);
      default: ;
    endcase
  endfunction

  function longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint log2_q16(longint v);
    int p;
    longint t, f, idx, rem;
    p = 0;
    t = v;
    if (v == 0) return 0;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    if (p >= 16) f = (v >> (p - 16)) & 64'hffff;
    else f = (v << (16 - p)) & 64'hffff;
    idx = f >> 12;
    rem = f & 64'hfff;
    return (longint'(p) << 16) + ltab[idx] + (((ltab[idx+1] - ltab[idx]) * rem) >>> 12);
  endfunction

  function jets_pkg::out_t escape_value(jets_pkg::in_t px);
    longint col, row, zr, zi, zr2, zi2, nr, ni, l1, l2, r, cnt;
    int unsigned i;
    jets_pkg::out_t o;
    col = px.pixel_col;
    row = px.pixel_row;
    i = 0;
    zr = clip(min_re + (col * (max_re - min_re)) / 1024);
    zi = clip(max_im - (row * (max_im - min_im)) / 1024);
    zr2 = (zr * zr) >>> 28;
    zi2 = (zi * zi) >>> 28;
    while (zr2 + zi2 <= (64'sd4 <<< 28) && i < limit) begin
      ni = clip(((zr * zi) >>> 27) + c_im);
      nr = clip(zr2 - zi2 + c_re);
      zr = nr;
      zi = ni;
      zr2 = (zr * zr) >>> 28;
      zi2 = (zi * zi) >>> 28;
      i++;
    end
    if (i == limit) begin
      o.inside_set = 1'b1;
      cnt = longint'(limit) << 8;
    end else begin
      o.inside_set = 1'b0;
      l1 = log2_q16(zr2 + zi2) - (64'sd28 <<< 16);
      if (l1 < 1) l1 = 1;
      l2 = log2_q16(l1) - (64'sd16 <<< 16);
      r = (longint'(i + 2) << 16) + jets_pkg::NEG_LOG2_LN2_Q16 - l2;
      if (r < 0) cnt = 0;
      else begin
        cnt = (r + 128) >>> 8;
        if (cnt > (longint'(limit) << 8)) cnt = longint'(limit) << 8;
      end
    end
    o.smooth_count = cnt[19:0];
    return o;
  endfunction

  function void note(jets_pkg::in_t px);
    expected_counts.push_back(escape_value(px));
  endfunction

  function void check(jets_pkg::out_t got);
    jets_pkg::out_t want;
    results++;
    if (expected_counts.size() == 0) begin
      $display("%0t: unexpected transaction actual count=%0d inside=%0b",
               $time, got.smooth_count, got.inside_set);
      errors++;
      return;
    end
    want = expected_counts.pop_front();
    if (want.inside_set) inside_hits++;
    if (!want.inside_set && want.smooth_count == (limit << 8)) sat_hits++;
    if (got.smooth_count !== want.smooth_count) begin
      $display("%0t: smooth_count expected %0d actual %0d", $time, want.smooth_count,
               got.smooth_count);
      errors++;
    end
    if (got.inside_set !== want.inside_set) begin
      $display("%0t: inside_set expected %0b actual %0b", $time, want.inside_set,
               got.inside_set);
      errors++;
    end
  endfunction
endclass

module julia_escape_time_smooth_test;

  localparam int IDLE_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = jets_pkg::REG_CONST_REAL;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  jets_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  jets_pkg::out_t out_data;

  escape_scoreboard pixels = new();
  bit hold_req = 0;
  int sent = 0;
  int idle_cycles = 0;

  julia_escape_time_smooth DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  // result side: sample and check at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pixels.check(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    int run;
    bit level;
    run = 0;
    level = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
        run = 0;
      end else begin
        if (run == 0) begin
          level = ($urandom_range(0, 2) == 0);
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        end
        run--;
        out_stall <= level;
      end
    end
  end

  task automatic send_pixel(jets_pkg::in_t px);
    int r, gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels.note(px);
    sent++;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 80);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixels.expected_counts.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    pixels.configure(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_view(int cr, int ci, int minr, int maxr, int mini, int maxi,
                          logic [11:0] lim);
    drain();
    write_reg(jets_pkg::REG_CONST_REAL, cr);
    write_reg(jets_pkg::REG_CONST_IMAG, ci);
    write_reg(jets_pkg::REG_VIEW_MIN_REAL, minr);
    write_reg(jets_pkg::REG_VIEW_MAX_REAL, maxr);
    write_reg(jets_pkg::REG_VIEW_MIN_IMAG, mini);
    write_reg(jets_pkg::REG_VIEW_MAX_IMAG, maxi);
    write_reg(jets_pkg::REG_ITER_LIMIT, 32'(lim));
  endtask

  task automatic random_pixels(int n);
    jets_pkg::in_t px;
    repeat (n) begin
      px.pixel_col = 10'($urandom_range(0, 1023));
      px.pixel_row = 10'($urandom_range(0, 1023));
      send_pixel(px);
    end
  endtask

  task automatic corner_pixels();
    jets_pkg::in_t px;
    int k;
    logic [9:0] vals[6] = '{10'd0, 10'd1023, 10'd512, 10'h155, 10'h2aa, 10'd256};
    for (k = 0; k < 12; k++) begin
      px.pixel_col = vals[k % 6];
      px.pixel_row = vals[(k * 5 + 1) % 6];
      send_pixel(px);
    end
  endtask

  function automatic int rand_q(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    int k;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset settings, then directed corners
    corner_pixels();

    // classic dendrite-like constant, default limit, with a long output hold
    set_view(-214748365, 41875931, -536870912, 536870912, -536870912, 536870912, 12'd100);
    corner_pixels();
    hold_req = 1;
    random_pixels(300);

    // widest window and extreme constants, limit of one
    set_view(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 12'd1);
    corner_pixels();
    random_pixels(100);

    // inverted window, limit of zero
    set_view(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
             32'sh7fffffff, 32'sh80000000, 12'd0);
    random_pixels(20);

    // largest limit, few pixels since inside points run long
    set_view(76504104, 2684355, -402653184, 402653184, -402653184, 402653184, 12'hfff);
    corner_pixels();

    set_view(-268435456, 0, -536870912, 536870912, -536870912, 536870912, 12'd255);
    random_pixels(200);

    for (k = 0; k < 15; k++) begin
      if (k % 5 == 4)
        set_view(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), 12'($urandom_range(1, 40)));
      else
        set_view(rand_q(268435456), rand_q(268435456), -rand_q(536870912) - 268435456,
                 rand_q(536870912) + 268435456, -402653184 + rand_q(134217728),
                 402653184 + rand_q(134217728), 12'($urandom_range(1, 60)));
      random_pixels(50);
    end

    drain();
    $display("covered %0d pixels, %0d results, %0d inside the set, %0d clipped at the limit",
             sent, pixels.results, pixels.inside_hits, pixels.sat_hits);
    if (pixels.errors == 0 && pixels.expected_counts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
